// ===== hdl/binary_morphology_3x3_defines.svh =====
// Assertion macros for the binary morphology block and its checker.
// No dependencies; included by files that carry assertions.
`ifndef BINARY_MORPHOLOGY_3X3_DEFINES_SVH
`define BINARY_MORPHOLOGY_3X3_DEFINES_SVH

// Checked outside reset only.
`define BM3_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) expr) else $error(msg);

// Checked on every edge, reset included.
`define BM3_ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) expr) else $error(msg);

`endif

// ===== hdl/bm3_pkg.sv =====
// Shared types, constants and helpers of the binary morphology block.
// No dependencies.
package bm3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WIDTH_W   = COL_W + 1;
  localparam int OUT_ROW_W = $clog2(MAX_HEIGHT);
  localparam int HEIGHT_W  = OUT_ROW_W + 1;
  localparam int ROW_W     = HEIGHT_W;
  localparam int PIX_W     = 8;
  localparam int CFG_W     = 13;
  localparam int IDX_W     = 2;
  localparam int MODE_W    = 2;
  localparam int WIN_ROWS  = 3;
  localparam int WIN_CELLS = 2;

  localparam logic [PIX_W-1:0] PIX_ON  = 8'd255;
  localparam logic [PIX_W-1:0] PIX_OFF = 8'd0;

  localparam logic [MODE_W-1:0] MODE_DILATE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ERODE    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BOUNDARY = 2'd2;

  localparam logic [IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

  typedef struct packed {
    logic             cmd;
    logic [PIX_W-1:0] pixel_in;
  } req_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             last_of_frame;
  } res_t;

  // bit 1 upper line, bit 0 middle line
  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic [1:0]       data;
  } ls_wr_t;

  typedef struct packed {
    logic en;
    logic clr;
    logic kill;
  } cell_ctl_t;

  typedef struct packed {
    logic [WIN_ROWS-1:0] col;
    logic                any;
    logic                all;
  } cell_out_t;

  function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] v);
    logic [WIDTH_W-1:0] r;
    r = v;
    if (v == '0) r = WIDTH_W'(1);
    else if (v > WIDTH_W'(MAX_WIDTH)) r = WIDTH_W'(MAX_WIDTH);
    return r;
  endfunction

  function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [HEIGHT_W-1:0] v);
    logic [HEIGHT_W-1:0] r;
    r = v;
    if (v == '0) r = HEIGHT_W'(1);
    else if (v > HEIGHT_W'(MAX_HEIGHT)) r = HEIGHT_W'(MAX_HEIGHT);
    return r;
  endfunction

endpackage

// ===== hdl/binary_morphology_3x3.sv =====
// Binary morphology (dilate, erode, boundary) on a raster pixel stream.
// Depends on bm3_pkg, bm3_line_store and bm3_cell.
//
// Requests (req) carry one pixel or a drain tick; results (res) carry 0 or
// 255 and a last-of-frame flag. Both channels use valid/ready.
// One request per clock is taken while req_ready is high; the line-store read
// port and the window cells work at that rate with no stall of their own.
// A result is in its output register in the cycle after the request that
// causes it; in the stream it trails its pixel by one row plus one pixel,
// so width+1 drain ticks after the last pixel flush the frame.
// req_ready is low during reset and while a result is held and res_ready
// is low; the held result stays unchanged until taken.
// Reset sets mode to dilate, 640x480, and clears counters and window; the
// line stores need no clearing, since every read whose value is used in a
// frame is of an entry already written in that frame.
// Configuration must be written via cfg_write/cfg_index/cfg_data while idle
// (not enforced by the block); writing width or height starts a new frame.
module binary_morphology_3x3
  import bm3_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_t             req,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res
);

  logic [MODE_W-1:0]    mode;
  logic [WIDTH_W-1:0]   width;
  logic [HEIGHT_W-1:0]  height;

  logic [COL_W-1:0]     in_column, in_column_next;
  logic [ROW_W-1:0]     in_row, in_row_next;
  logic [COL_W-1:0]     out_column, out_column_next;
  logic [OUT_ROW_W-1:0] out_row, out_row_next;

  logic                accept, step, drain, row_live;
  logic                col_first, col_last, out_col_last, out_last;
  logic                emit, frame_done, restart_cfg, result;
  logic                win_any, win_all, center;
  logic [1:0]          ls_q;
  logic [WIN_ROWS-1:0] col, newest;
  ls_wr_t              ls_wr;
  cell_ctl_t           cell_ctl [WIN_CELLS];
  cell_out_t           cell_q [WIN_CELLS];

  assign req_ready = !rst && (!res_valid || res_ready);
  assign accept    = req_valid && req_ready;
  assign drain     = (req.cmd == CMD_DRAIN);
  assign row_live  = in_row < height;
  assign step      = accept && !(drain && row_live);

  assign restart_cfg = cfg_write && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));

  assign col_first    = (in_column == '0);
  assign col_last     = (WIDTH_W'(in_column) + WIDTH_W'(1)) >= width;
  assign out_col_last = (WIDTH_W'(out_column) + WIDTH_W'(1)) >= width;
  assign out_last     = out_col_last && ((HEIGHT_W'(out_row) + HEIGHT_W'(1)) >= height);

  // window rows: 0 upper, 1 middle, 2 current
  assign col[0] = (in_row >= ROW_W'(2)) && ls_q[1];
  assign col[1] = (in_row >= ROW_W'(1)) && (in_row <= height) && ls_q[0];
  assign col[2] = !drain && row_live && (req.pixel_in != '0);

  assign emit       = col_first ? (in_row >= ROW_W'(2)) : (in_row >= ROW_W'(1));
  assign frame_done = step && emit && out_last;

  bm3_line_store u_line_store (
    .clk   (clk),
    .rst   (rst),
    .wr    (ls_wr),
    .raddr (in_column_next),
    .q     (ls_q)
  );

  assign ls_wr.en   = step && !restart_cfg;
  assign ls_wr.addr = in_column;
  assign ls_wr.data = {ls_q[0], col[2]};

  for (genvar k = 0; k < WIN_CELLS; k++) begin : g_cell
    assign cell_ctl[k].en   = step;
    assign cell_ctl[k].clr  = restart_cfg || frame_done;
    assign cell_ctl[k].kill = (k != 0) && col_first;

    bm3_cell u_cell (
      .clk (clk),
      .rst (rst),
      .ctl (cell_ctl[k]),
      .d   ((k == 0) ? col : cell_q[(k == 0) ? 0 : k - 1].col),
      .q   (cell_q[k])
    );
  end

  // at a row start the window is judged with an empty newest column
  assign newest  = col_first ? '0 : col;
  assign win_any = cell_q[1].any | cell_q[0].any | (|newest);
  assign win_all = cell_q[1].all & cell_q[0].all & (&newest);
  assign center  = cell_q[0].col[1];

  always_comb begin
    case (mode)
      MODE_DILATE:   result = win_any;
      MODE_ERODE:    result = win_all;
      MODE_BOUNDARY: result = center && !win_all;
      default:       result = 1'b0;
    endcase
  end

  always_comb begin
    in_column_next  = in_column;
    in_row_next     = in_row;
    out_column_next = out_column;
    out_row_next    = out_row;
    if (restart_cfg || frame_done) begin
      in_column_next  = '0;
      in_row_next     = '0;
      out_column_next = '0;
      out_row_next    = '0;
    end else if (step) begin
      if (col_last) begin
        in_column_next = '0;
        in_row_next    = in_row + ROW_W'(1);
      end else begin
        in_column_next = in_column + COL_W'(1);
      end
      if (emit) begin
        if (out_col_last) begin
          out_column_next = '0;
          out_row_next    = out_row + OUT_ROW_W'(1);
        end else begin
          out_column_next = out_column + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_DILATE;
      width      <= WIDTH_RESET;
      height     <= HEIGHT_RESET;
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_MODE:   mode   <= cfg_data[MODE_W-1:0];
          REG_WIDTH:  width  <= clamp_width(cfg_data[WIDTH_W-1:0]);
          REG_HEIGHT: height <= clamp_height(cfg_data[HEIGHT_W-1:0]);
          default:    ;
        endcase
      end
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step && emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      res.pixel_out     <= result ? PIX_ON : PIX_OFF;
      res.last_of_frame <= out_last;
    end
  end

endmodule

// ===== hdl/bm3_line_store.sv =====
// Two line stores packed side by side in one memory, registered read with
// write-to-read bypass. Depends on bm3_pkg.
module bm3_line_store
  import bm3_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  ls_wr_t           wr,
  input  logic [COL_W-1:0] raddr,
  output logic [1:0]       q
);

  logic [1:0] mem [MAX_WIDTH];
  logic [1:0] mem_q;
  logic [1:0] fwd_data;
  logic       fwd;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    mem_q    <= mem[raddr];
    fwd_data <= wr.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else begin
      fwd <= wr.en && (wr.addr == raddr);
    end
  end

  assign q = fwd ? fwd_data : mem_q;

endmodule

// ===== hdl/bm3_cell.sv =====
// One column of the 3x3 window: holds three bits, hands them to the next
// cell, reports their OR and AND. Depends on bm3_pkg.
module bm3_cell
  import bm3_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cell_ctl_t           ctl,
  input  logic [WIN_ROWS-1:0] d,
  output cell_out_t           q
);

  logic [WIN_ROWS-1:0] col;

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      col <= '0;
    end else if (ctl.en) begin
      col <= ctl.kill ? '0 : d;
    end
  end

  assign q.col = col;
  assign q.any = |col;
  assign q.all = &col;

endmodule

// ===== hdl/bm3_checker.sv =====
`include "binary_morphology_3x3_defines.svh"
// Port-level checks of the binary morphology block, bound to its top level.
// Depends on bm3_pkg and binary_morphology_3x3_defines.svh.
module bm3_checker
  import bm3_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             req_ready,
  input logic             res_valid,
  input logic             res_ready,
  input res_t             res
);

  `BM3_ASSERT_ALWAYS(a_idle_after_reset, $past(rst) |-> !res_valid, "result valid after reset")

  `BM3_ASSERT(a_binary_out, res_valid |-> (res.pixel_out == PIX_ON || res.pixel_out == PIX_OFF), "result not 0 or 255")

  `BM3_ASSERT(a_ready_when_empty, !res_valid |-> req_ready, "request stalled with no result held")

  `BM3_ASSERT(a_hold_stalled, res_valid && !res_ready |=> res_valid && $stable(res), "stalled result changed")

endmodule

bind binary_morphology_3x3 bm3_checker u_bm3_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);
